// File: src/ogi_pkg.sv
`default_nettype none

package ogi_pkg;

  // Grid limits
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_RADIUS  = 15;

  // Field and register widths
  localparam int DIM_W   = 11;
  localparam int R_W     = 4;
  localparam int VAL_W   = 8;
  localparam int COORD_W = 10;
  localparam int GAP_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Position counters span the padded frame
  localparam int POS_W = $clog2(MAX_WIDTH + MAX_RADIUS + 1) > $clog2(MAX_HEIGHT + MAX_RADIUS + 1)
                       ? $clog2(MAX_WIDTH + MAX_RADIUS + 1)
                       : $clog2(MAX_HEIGHT + MAX_RADIUS + 1);

  // Column gap store
  localparam int COL_AW = $clog2(MAX_WIDTH);

  // Value delay line
  localparam int DELAY_DEPTH = MAX_RADIUS * (MAX_WIDTH + MAX_RADIUS) + MAX_RADIUS;
  localparam int DLY_AW      = $clog2(DELAY_DEPTH);

  // Output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam logic [VAL_W-1:0] OCC_CODE = VAL_W'(100);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INFLATE_CELLS = CFG_IDX_W'(2);

  // Reset values
  localparam logic [DIM_W-1:0] RST_GRID_WIDTH    = DIM_W'(1024);
  localparam logic [DIM_W-1:0] RST_GRID_HEIGHT   = DIM_W'(1024);
  localparam logic [R_W-1:0]   RST_INFLATE_CELLS = R_W'(4);

  // Working configuration with the values derived from it
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [R_W-1:0]    radius;
    logic [POS_W-1:0]  span_c;
    logic [POS_W-1:0]  span_r;
    logic [GAP_W-1:0]  sat;
    logic [DLY_AW-1:0] rd_off;
    logic              dly_zero;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } out_word_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > hi) res = hi;
    return res;
  endfunction

  function automatic cfg_t cfg_derive(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                      logic [R_W-1:0] r);
    cfg_t             c;
    logic [DLY_AW:0]  r_e;
    logic [DLY_AW:0]  s_e;
    logic [DLY_AW:0]  dly;
    c.width  = w;
    c.height = h;
    c.radius = r;
    c.span_c = POS_W'(w) + POS_W'(r);
    c.span_r = POS_W'(h) + POS_W'(r);
    c.sat    = GAP_W'({r, 1'b1});
    r_e      = (DLY_AW+1)'(r);
    s_e      = (DLY_AW+1)'(c.span_c);
    dly      = r_e * s_e + r_e;
    c.rd_off = DLY_AW'((DLY_AW+1)'(DELAY_DEPTH) - dly);
    c.dly_zero = (dly == '0);
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/ogi_ram.sv
`default_nettype none

module ogi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the entry being written gets old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/ogi_cfg.sv
`default_nettype none

module ogi_cfg import ogi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [DIM_W-1:0] w_nxt;
  logic [DIM_W-1:0] h_nxt;
  logic [R_W-1:0]   r_nxt;
  logic [R_W-1:0]   r_wr;

  // Clamp the written word and recompute the derived values
  always_comb begin
    w_nxt = cfg_r.width;
    h_nxt = cfg_r.height;
    r_nxt = cfg_r.radius;
    r_wr  = cfg_wdata[R_W-1:0];
    if (r_wr > R_W'(MAX_RADIUS)) r_wr = R_W'(MAX_RADIUS);
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    w_nxt = clamp_dim(cfg_wdata, DIM_W'(MAX_WIDTH));
        REG_GRID_HEIGHT:   h_nxt = clamp_dim(cfg_wdata, DIM_W'(MAX_HEIGHT));
        REG_INFLATE_CELLS: r_nxt = r_wr;
        default:           ;
      endcase
    end
    cfg_nxt = cfg_derive(w_nxt, h_nxt, r_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_derive(RST_GRID_WIDTH, RST_GRID_HEIGHT, RST_INFLATE_CELLS);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: src/ogi_out_fifo.sv
`default_nettype none

module ogi_out_fifo import ogi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire out_word_t   push_word,
  input  wire logic        pop,
  output logic             out_valid,
  output out_word_t        out_word,
  output logic [OUT_AW:0]  fill
);

  out_word_t           mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0]   wr_ptr_r;
  logic [OUT_AW-1:0]   rd_ptr_r;
  logic [OUT_AW:0]     cnt_r;

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + OUT_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + OUT_AW'(1);
      cnt_r <= cnt_r + (OUT_AW+1)'(push) - (OUT_AW+1)'(pop);
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign fill      = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (OUT_AW+1)'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> out_valid)
    else $error("result queue underflow");

endmodule

`default_nettype wire

// File: src/occupancy_grid_inflation_unit.sv
`default_nettype none

// Channel  | Ports                                         | Direction
// input    | in_valid/in_ready, in_cell_value, in_frame_start | into block
// result   | out_valid/out_ready, out_result_value/col/row, out_frame_last | out of block
// config   | cfg_wr_en, cfg_index, cfg_wdata               | into block, write only
//
// One word accepted per cycle while in_ready is high; a result passes the stage 1 register and then the result queue.
// Rate is set by the column gap memory read-modify-write, one column per cycle with
// forwarding when the same column is hit on consecutive cycles.
// After reset a clearing pass zeroes all 1024 entries of the column gap memory; in_ready is low.
// A stall on the result side fills a four-word queue; in_ready drops once the queued
// words plus the word in the column stage reach four.

module occupancy_grid_inflation_unit import ogi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [VAL_W-1:0]     in_cell_value,
  input  wire logic                 in_frame_start,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [VAL_W-1:0]          out_result_value,
  output logic [COORD_W-1:0]        out_result_col,
  output logic [COORD_W-1:0]        out_result_row,
  output logic                      out_frame_last,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata
);

  typedef struct packed {
    logic [COL_AW-1:0]  x;
    logic [COORD_W-1:0] yy;
    logic               hit_h;
    logic               row0;
    logic               col_ok;
    logic               emit;
    logic               last;
    logic               dly_zero;
    logic [VAL_W-1:0]   val;
  } s1_t;

  cfg_t cfg;

  ogi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  logic              accept;
  logic [POS_W-1:0]  pos_col_r, pos_col_nxt;
  logic [POS_W-1:0]  pos_row_r, pos_row_nxt;
  logic [GAP_W-1:0]  row_gap_r;
  logic [DLY_AW-1:0] dly_wr_ptr_r, dly_wr_ptr_nxt;
  logic              clr_busy_r;
  logic [COL_AW-1:0] clr_cnt_r;
  s1_t               s1_r, s1_nxt;
  logic              s1_v_r;
  logic              fwd_r, fwd_nxt;
  logic [GAP_W-1:0]  fwd_val_r;

  // Stage 0 signals
  logic [POS_W-1:0]  c0, y0, cx, ry, r_e, w_e, h_e;
  logic [GAP_W-1:0]  prior_h, gap_h;
  logic [GAP_W:0]    inc_h;
  logic              occ0, col_ok0, col_end, row_end;
  logic [DLY_AW:0]   dly_sum;
  logic [DLY_AW-1:0] dly_raddr;

  // Stage 1 signals
  logic [GAP_W-1:0]  col_q, prior_v, gap_v;
  logic [GAP_W:0]    inc_v;
  logic              hit_v;
  logic [VAL_W-1:0]  dly_q;
  out_word_t         res_word;
  logic              push;

  // Column memory ports
  logic              col_we;
  logic [COL_AW-1:0] col_waddr;
  logic [GAP_W-1:0]  col_wdata;

  // Result queue
  logic              pop;
  out_word_t         out_word;
  logic [OUT_AW:0]   fill;
  logic [OUT_AW+1:0] inflight;

  assign inflight = (OUT_AW+2)'(fill) + (OUT_AW+2)'(s1_v_r);
  assign in_ready = !clr_busy_r && (inflight < (OUT_AW+2)'(OUT_DEPTH));
  assign accept   = in_valid && in_ready;

  // Stage 0: position, row run and addresses
  always_comb begin
    r_e = POS_W'(cfg.radius);
    w_e = POS_W'(cfg.width);
    h_e = POS_W'(cfg.height);
    c0  = in_frame_start ? '0 : pos_col_r;
    y0  = in_frame_start ? '0 : pos_row_r;
    cx  = c0 - r_e;
    ry  = y0 - r_e;

    prior_h = (c0 == '0) ? cfg.sat : row_gap_r;
    occ0    = (c0 < w_e) && (y0 < h_e) && (in_cell_value == OCC_CODE);
    inc_h   = {1'b0, prior_h} + (GAP_W+1)'(1);
    if (occ0) gap_h = '0;
    else if (inc_h > {1'b0, cfg.sat}) gap_h = cfg.sat;
    else gap_h = inc_h[GAP_W-1:0];

    col_ok0 = (c0 >= r_e) && (cx < w_e);

    s1_nxt.x        = cx[COL_AW-1:0];
    s1_nxt.yy       = ry[COORD_W-1:0];
    s1_nxt.hit_h    = (gap_h < cfg.sat);
    s1_nxt.row0     = (y0 == '0);
    s1_nxt.col_ok   = col_ok0;
    s1_nxt.emit     = col_ok0 && (y0 >= r_e) && (ry < h_e);
    s1_nxt.last     = (cx == w_e - POS_W'(1)) && (ry == h_e - POS_W'(1));
    s1_nxt.dly_zero = cfg.dly_zero;
    s1_nxt.val      = in_cell_value;

    fwd_nxt = accept && s1_v_r && s1_r.col_ok && col_ok0 && (s1_r.x == cx[COL_AW-1:0]);

    // Advance over the padded frame
    col_end = ({1'b0, c0} + (POS_W+1)'(1)) >= {1'b0, cfg.span_c};
    row_end = ({1'b0, y0} + (POS_W+1)'(1)) >= {1'b0, cfg.span_r};
    pos_col_nxt = pos_col_r;
    pos_row_nxt = pos_row_r;
    if (accept) begin
      if (col_end) begin
        pos_col_nxt = '0;
        pos_row_nxt = row_end ? '0 : y0 + POS_W'(1);
      end else begin
        pos_col_nxt = c0 + POS_W'(1);
        pos_row_nxt = y0;
      end
    end

    // Delay line read point trails the write pointer
    dly_sum   = {1'b0, dly_wr_ptr_r} + {1'b0, cfg.rd_off};
    dly_raddr = (dly_sum >= (DLY_AW+1)'(DELAY_DEPTH))
              ? DLY_AW'(dly_sum - (DLY_AW+1)'(DELAY_DEPTH))
              : dly_sum[DLY_AW-1:0];
    dly_wr_ptr_nxt = (dly_wr_ptr_r == DLY_AW'(DELAY_DEPTH - 1))
                   ? '0 : dly_wr_ptr_r + DLY_AW'(1);
  end

  // Stage 1: column run and result
  always_comb begin
    prior_v = s1_r.row0 ? cfg.sat : (fwd_r ? fwd_val_r : col_q);
    inc_v   = {1'b0, prior_v} + (GAP_W+1)'(1);
    if (s1_r.hit_h) gap_v = '0;
    else if (inc_v > {1'b0, cfg.sat}) gap_v = cfg.sat;
    else gap_v = inc_v[GAP_W-1:0];
    hit_v = (gap_v < cfg.sat);

    res_word.value = hit_v ? OCC_CODE : (s1_r.dly_zero ? s1_r.val : dly_q);
    res_word.col   = s1_r.x;
    res_word.row   = s1_r.yy;
    res_word.last  = s1_r.last;
    push = s1_v_r && s1_r.emit;

    // Clearing pass owns the write port after reset
    if (clr_busy_r) begin
      col_we    = 1'b1;
      col_waddr = clr_cnt_r;
      col_wdata = '0;
    end else begin
      col_we    = s1_v_r && s1_r.col_ok;
      col_waddr = s1_r.x;
      col_wdata = gap_v;
    end
  end

  ogi_ram #(.WIDTH(GAP_W), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (accept),
    .raddr (cx[COL_AW-1:0]),
    .rdata (col_q)
  );

  ogi_ram #(.WIDTH(VAL_W), .DEPTH(DELAY_DEPTH)) u_dly_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (dly_wr_ptr_r),
    .wdata (in_cell_value),
    .re    (accept),
    .raddr (dly_raddr),
    .rdata (dly_q)
  );

  // Hold stage 1 payload and forwarded gap
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    fwd_val_r <= gap_v;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_col_r    <= '0;
      pos_row_r    <= '0;
      row_gap_r    <= '0;
      dly_wr_ptr_r <= '0;
      s1_v_r       <= 1'b0;
      fwd_r        <= 1'b0;
      clr_busy_r   <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      pos_col_r <= pos_col_nxt;
      pos_row_r <= pos_row_nxt;
      if (accept) begin
        row_gap_r    <= gap_h;
        dly_wr_ptr_r <= dly_wr_ptr_nxt;
      end
      s1_v_r <= accept;
      fwd_r  <= fwd_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + COL_AW'(1);
        if (clr_cnt_r == COL_AW'(MAX_WIDTH - 1)) clr_busy_r <= 1'b0;
      end
    end
  end

  assign pop = out_valid && out_ready;

  ogi_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (res_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .fill      (fill)
  );

  assign out_result_value = out_word.value;
  assign out_result_col   = out_word.col;
  assign out_result_row   = out_word.row;
  assign out_frame_last   = out_word.last;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("word accepted during column clear");

  a_fwd_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_v_r && $past(s1_v_r)))
    else $error("forward without consecutive column access");

  a_emit_has_column: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_r.emit) |-> s1_r.col_ok)
    else $error("result emitted outside an output column");

endmodule

`default_nettype wire
